### rtl/core/lepl_pkg.sv
// Shared types, constants and helpers for the luminance extreme pixel locator.
`timescale 1ns / 1ps

package lepl_pkg;

  // Field widths of the pixel and result items
  localparam int ColorW = 8;
  localparam int LevelW = 9;
  localparam int LumaW  = 15;
  localparam int WidthW = 13;
  localparam int PosXW  = 12;
  localparam int PosYW  = 14;

  // Stream bus widths
  localparam int InDataW  = 40;
  localparam int OutDataW = 80;
  localparam int CfgIdxW  = 2;

  // Luma of pure white under the 30/59/11 weighting
  localparam logic [LumaW-1:0] LumaTop = 15'd25500;

  // Reset value of the image width configuration register
  localparam logic [WidthW-1:0] WidthReset = 13'd128;

  // Output field offsets inside m_axis_tdata
  localparam int OutLumaLo = 59;
  localparam int OutLumaHi = 73;

  typedef enum logic {
    MODE_LOAD  = 1'b0,
    MODE_FETCH = 1'b1
  } mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_IMAGE_WIDTH    = 2'd0,
    REG_SEEK_BRIGHTEST = 2'd1,
    REG_ALL_MATCHES    = 2'd2
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LUMA,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_DIV,
    ST_RESP
  } state_e;

  // One stored pixel with its precomputed luma
  typedef struct packed {
    logic [LumaW-1:0]  luma;
    logic [LevelW-1:0] level;
    logic [ColorW-1:0] blue;
    logic [ColorW-1:0] green;
    logic [ColorW-1:0] red;
  } pixel_word_t;

  // One result item
  typedef struct packed {
    logic              found;
    logic [PosXW-1:0]  pos_x;
    logic [PosYW-1:0]  pos_y;
    logic [ColorW-1:0] red;
    logic [ColorW-1:0] green;
    logic [ColorW-1:0] blue;
    logic [LevelW-1:0] level;
    logic [LumaW-1:0]  luma;
    logic              overflowed;
  } result_t;

  // Luma weight of color channel k (red, green, blue)
  function automatic logic [6:0] luma_weight(input logic [1:0] k);
    logic [6:0] w;
    case (k)
      2'd0:    w = 7'd30;
      2'd1:    w = 7'd59;
      default: w = 7'd11;
    endcase
    return w;
  endfunction

endpackage

### rtl/core/lepl_luma.sv
// Shared multiply-accumulate unit: forms 30R+59G+11B, one channel per step.
`timescale 1ns / 1ps

module lepl_luma (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [lepl_pkg::ColorW-1:0] red_i,
  input  logic [lepl_pkg::ColorW-1:0] green_i,
  input  logic [lepl_pkg::ColorW-1:0] blue_i,
  output logic [lepl_pkg::LumaW-1:0]  luma_o,
  output logic                   done_o
);
  import lepl_pkg::*;

  logic [ColorW-1:0] red_q, green_q, blue_q;
  logic [LumaW-1:0]  acc_q, acc_d;
  logic [1:0]        step_q, step_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [ColorW-1:0] operand;
  logic [LumaW-1:0]  product;

  // Pick the channel for this step and weight it
  always_comb begin
    case (step_q)
      2'd0:    operand = red_q;
      2'd1:    operand = green_q;
      default: operand = blue_q;
    endcase
    product = LumaW'(operand * luma_weight(step_q));
  end

  // Advance one channel per cycle
  always_comb begin
    acc_d  = acc_q;
    step_d = step_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      acc_d  = '0;
      step_d = 2'd0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      acc_d  = acc_q + product;
      step_d = step_q + 2'd1;
      if (step_q == 2'd2) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Capture the operands at start
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      red_q   <= red_i;
      green_q <= green_i;
      blue_q  <= blue_i;
    end
    acc_q <= acc_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= 2'd0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      step_q <= step_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  assign luma_o = acc_q;
  assign done_o = done_q;

endmodule

### rtl/core/lepl_div.sv
// Restoring divider, one quotient bit per cycle: splits a raster index into row and column.
`timescale 1ns / 1ps

module lepl_div #(
  parameter int DW = 15
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [DW-1:0]                dividend_i,
  input  logic [lepl_pkg::WidthW-1:0]  divisor_i,
  output logic [DW-1:0]                quo_o,
  output logic [lepl_pkg::WidthW-1:0]  rem_o,
  output logic                         done_o
);
  import lepl_pkg::*;

  localparam int CntW = $clog2(DW + 1);

  logic [DW-1:0]     quo_q, quo_d;
  logic [WidthW-1:0] rem_q, rem_d;
  logic [WidthW-1:0] div_q;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [WidthW:0]   trial;

  assign trial = {rem_q, quo_q[DW-1]};

  // Shift in one dividend bit, subtract when the divisor fits
  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      cnt_d  = CntW'(DW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, div_q}) begin
        rem_d = WidthW'(trial - {1'b0, div_q});
        quo_d = {quo_q[DW-2:0], 1'b1};
      end else begin
        rem_d = trial[WidthW-1:0];
        quo_d = {quo_q[DW-2:0], 1'b0};
      end
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      div_q <= divisor_i;
    end
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  assign quo_o  = quo_q;
  assign rem_o  = rem_q;
  assign done_o = done_q;

endmodule

### rtl/core/luminance_extreme_pixel_locator_core.sv
// Top level: pixel store, load and scan sequencer, result register.
// Load: accept, three multiply-accumulate steps, store write; a pixel that arrives when
// the store is full is dropped at accept. Fetch: a store read and a luma compare per
// scanned entry, a last pass through the read state when the scan runs off the end, the
// divider on a match, and accept and result hand-off, plus any output stall.
// One item at a time; s_axis_tready is high only while the sequencer is idle.
// Reset (rst_ni low, asynchronous) empties the image and restores the register defaults.
`timescale 1ns / 1ps

module luminance_extreme_pixel_locator_core #(
  parameter int MAX_PIXELS = 16384
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Input stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // tdata: red[7:0], green[15:8], blue[23:16], level[32:24], zero fill
  input  logic [lepl_pkg::InDataW-1:0]    s_axis_tdata,
  // tuser: mode
  input  logic                            s_axis_tuser,
  // tlast: last_pixel
  input  logic                            s_axis_tlast,
  // Output stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // tdata: pos_x[11:0], pos_y[25:12], out_red[33:26], out_green[41:34],
  //        out_blue[49:42], out_level[58:50], luma[73:59], overflowed[74], zero fill
  output logic [lepl_pkg::OutDataW-1:0]   m_axis_tdata,
  // tuser: found
  output logic                            m_axis_tuser,
  // Configuration writes
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [lepl_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [lepl_pkg::WidthW-1:0]     cfg_data_i
);
  import lepl_pkg::*;

  localparam int CW = $clog2(MAX_PIXELS + 1);
  localparam int AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam int DW = (CW < 2) ? 2 : CW;

  // Configuration registers
  logic [WidthW-1:0] width_q;
  logic              bright_q;
  logic              all_q;
  logic [WidthW-1:0] width_eff;

  // Image state
  state_e            state_q, state_d;
  logic [CW-1:0]     count_q, count_d;
  logic [CW-1:0]     scan_q, scan_d;
  logic [CW-1:0]     idx_q, idx_d;
  logic [LumaW-1:0]  extreme_q, extreme_d;
  logic              complete_q, complete_d;
  logic              ovf_q, ovf_d;
  logic              last_q, last_d;

  // Pixel held during the luma computation
  pixel_word_t       pix_q, pix_d;

  // Pixel store
  pixel_word_t       mem [MAX_PIXELS];
  pixel_word_t       rd_q;
  logic              mem_we;
  logic              mem_re;
  pixel_word_t       wr_word;

  // Results
  result_t           res_q, res_d;
  result_t           out_q, out_d;
  logic              out_valid_q, out_valid_d;

  // Shared units
  logic              luma_start;
  logic [LumaW-1:0]  luma_val;
  logic              luma_done;
  logic              div_start;
  logic [DW-1:0]     div_quo;
  logic [WidthW-1:0] div_rem;
  logic              div_done;
  logic [DW+PosYW-1:0] quo_ext;

  logic [CW-1:0]     count_eff;
  logic [LumaW-1:0]  start_val;

  assign width_eff = (width_q == '0) ? WidthW'(1) : width_q;
  assign count_eff = complete_q ? '0 : count_q;
  assign start_val = (count_q == '0) ? (bright_q ? '0 : LumaTop) : extreme_q;
  assign quo_ext   = {{PosYW{1'b0}}, div_quo};

  assign wr_word = '{luma: luma_val, level: pix_q.level, blue: pix_q.blue,
                     green: pix_q.green, red: pix_q.red};

  lepl_luma u_luma (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (luma_start),
    .red_i   (s_axis_tdata[7:0]),
    .green_i (s_axis_tdata[15:8]),
    .blue_i  (s_axis_tdata[23:16]),
    .luma_o  (luma_val),
    .done_o  (luma_done)
  );

  lepl_div #(
    .DW (DW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (DW'(idx_q)),
    .divisor_i  (width_eff),
    .quo_o      (div_quo),
    .rem_o      (div_rem),
    .done_o     (div_done)
  );

  // Sequencer: next state and datapath controls
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    scan_d      = scan_q;
    idx_d       = idx_q;
    extreme_d   = extreme_q;
    complete_d  = complete_q;
    ovf_d       = ovf_q;
    last_d      = last_q;
    pix_d       = pix_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    luma_start  = 1'b0;
    div_start   = 1'b0;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    s_axis_tready = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        // Ready is high here, so a valid input is a transfer
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          if (s_axis_tuser == MODE_LOAD) begin
            // Start a new image after a completed one
            if (complete_q) begin
              count_d    = '0;
              scan_d     = '0;
              ovf_d      = 1'b0;
              complete_d = 1'b0;
            end
            if (count_eff < CW'(MAX_PIXELS)) begin
              pix_d.red   = s_axis_tdata[7:0];
              pix_d.green = s_axis_tdata[15:8];
              pix_d.blue  = s_axis_tdata[23:16];
              pix_d.level = s_axis_tdata[32:24];
              pix_d.luma  = '0;
              last_d      = s_axis_tlast;
              luma_start  = 1'b1;
              state_d     = ST_LUMA;
            end else begin
              // Drop the pixel
              ovf_d = 1'b1;
              if (s_axis_tlast) begin
                complete_d = 1'b1;
                scan_d     = '0;
              end
            end
          end else begin
            res_d            = '0;
            res_d.overflowed = ovf_q;
            if (complete_q) begin
              idx_d   = scan_q;
              state_d = ST_SCAN_RD;
            end else begin
              state_d = ST_RESP;
            end
          end
        end
      end

      ST_LUMA: begin
        if (luma_done) begin
          mem_we  = 1'b1;
          count_d = count_q + CW'(1);
          if (bright_q ? (luma_val > start_val) : (luma_val < start_val)) begin
            extreme_d = luma_val;
          end else begin
            extreme_d = start_val;
          end
          if (last_q) begin
            complete_d = 1'b1;
            scan_d     = '0;
          end
          state_d = ST_IDLE;
        end
      end

      ST_SCAN_RD: begin
        if (idx_q >= count_q) begin
          // Nothing left to report
          scan_d  = count_q;
          state_d = ST_RESP;
        end else begin
          mem_re  = 1'b1;
          state_d = ST_SCAN_CMP;
        end
      end

      ST_SCAN_CMP: begin
        if (rd_q.luma == extreme_q) begin
          res_d.found     = 1'b1;
          res_d.red       = rd_q.red;
          res_d.green     = rd_q.green;
          res_d.blue      = rd_q.blue;
          res_d.level     = rd_q.level;
          res_d.luma      = rd_q.luma;
          scan_d          = all_q ? (idx_q + CW'(1)) : count_q;
          div_start       = 1'b1;
          state_d         = ST_DIV;
        end else begin
          idx_d   = idx_q + CW'(1);
          state_d = ST_SCAN_RD;
        end
      end

      ST_DIV: begin
        if (div_done) begin
          res_d.pos_x = div_rem[PosXW-1:0];
          res_d.pos_y = quo_ext[PosYW-1:0];
          state_d     = ST_RESP;
        end
      end

      ST_RESP: begin
        // Hand the result to the output register once it is free
        if (!out_valid_q || m_axis_tready) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Pixel store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[count_q[AW-1:0]] <= wr_word;
    end
    if (mem_re) begin
      rd_q <= mem[idx_q[AW-1:0]];
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    pix_q <= pix_d;
    res_q <= res_d;
    out_q <= out_d;
    idx_q <= idx_d;
    last_q <= last_d;
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      scan_q      <= '0;
      extreme_q   <= LumaTop;
      complete_q  <= 1'b0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      scan_q      <= scan_d;
      extreme_q   <= extreme_d;
      complete_q  <= complete_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WidthReset;
      bright_q <= 1'b0;
      all_q    <= 1'b1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_IMAGE_WIDTH:    width_q  <= cfg_data_i;
        REG_SEEK_BRIGHTEST: bright_q <= cfg_data_i[0];
        REG_ALL_MATCHES:    all_q    <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  // Output stream
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.found;
  assign m_axis_tdata  = {5'b0, out_q.overflowed, out_q.luma, out_q.level, out_q.blue,
                          out_q.green, out_q.red, out_q.pos_y, out_q.pos_x};

endmodule

### rtl/core/lepl_checker.sv
// Port-level checks for the luminance extreme pixel locator and their bind.
`timescale 1ns / 1ps

module lepl_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          s_axis_tuser,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [lepl_pkg::OutDataW-1:0] m_axis_tdata,
  input logic                          m_axis_tuser
);
  import lepl_pkg::*;

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // A miss carries only the overflow flag
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[OutLumaHi:0] == '0)
    else $error("miss result carries pixel data");

  // A reported luma never exceeds white
  a_luma_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[OutLumaHi:OutLumaLo] <= LumaTop)
    else $error("luma out of range");

  // A fetch occupies the sequencer for at least the next cycle
  a_fetch_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == MODE_FETCH) |=> !s_axis_tready)
    else $error("input accepted right after a fetch");

endmodule

bind luminance_extreme_pixel_locator_core lepl_checker u_lepl_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
